/* hdl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, held off while reset is asserted
`define ASMS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds during reset
`define ASMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASMS_ASSERT(lbl, clk, rstn, prop, msg)
`define ASMS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* hdl/asms_pkg.sv */
package asms_pkg;

    localparam int DEPTH          = 64;
    localparam int MAX_ITEM_BYTES = 8;
    localparam int ADDR_W         = $clog2(DEPTH);
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int ITEM_W         = 64;
    localparam int IB_W           = 4;
    localparam int CAP_W          = 7;

    localparam logic OP_PUT    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam int REG_ITEM_BYTES = 0;
    localparam int REG_CAPACITY   = 1;

    typedef struct packed {
        logic              operation;
        logic [ITEM_W-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic             accepted;
        logic             found;
        logic             is_full;
        logic [CNT_W-1:0] fill_count;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fill_zero;
        logic scan_done;
        logic out_free;
    } dp_sts_t;

    function automatic logic [ITEM_W-1:0] byte_mask(input logic [IB_W-1:0] item_bytes);
        logic [ITEM_W-1:0] m;
        m = '0;
        for (int b = 0; b < MAX_ITEM_BYTES; b++)
        begin
            if (IB_W'(b) < item_bytes)
            begin
                m[b*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

    function automatic logic [CNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] capacity);
        logic [CNT_W-1:0] c;
        if (CNT_W'(capacity) > CNT_W'(DEPTH))
        begin
            c = CNT_W'(DEPTH);
        end
        else
        begin
            c = CNT_W'(capacity);
        end
        return c;
    endfunction

endpackage

/* hdl/asms_ctrl.sv */
`include "assert_macros.svh"

module asms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_op,
    input  asms_pkg::dp_sts_t   sts,
    output asms_pkg::ctrl_cmd_t cmd,
    output logic                req_stall
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        req_stall    = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (req_op == asms_pkg::OP_LOOKUP && !sts.fill_zero)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASMS_ASSERT(a_load_returns_idle, clk, rst_n, cmd.load_out |=> state_reg == ST_IDLE, "result load did not return to idle")
    `ASMS_ASSERT(a_scan_done_finish, clk, rst_n, (state_reg == ST_SCAN && sts.scan_done) |=> state_reg == ST_FINISH, "finished scan did not move to finish")
    `ASMS_ASSERT(a_finish_holds, clk, rst_n, (state_reg == ST_FINISH && !sts.out_free) |=> state_reg == ST_FINISH, "pending result dropped while output busy")

endmodule

/* hdl/asms_dp.sv */
`include "assert_macros.svh"

module asms_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  asms_pkg::ctrl_cmd_t                  cmd,
    output asms_pkg::dp_sts_t                    sts,
    input  asms_pkg::req_t                       req,
    input  logic [asms_pkg::IB_W-1:0]            item_bytes,
    input  logic [asms_pkg::CAP_W-1:0]           capacity,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output asms_pkg::rsp_t                       rsp
);

    logic [asms_pkg::ITEM_W-1:0] mem [asms_pkg::DEPTH];

    logic [asms_pkg::ITEM_W-1:0] mask;
    logic [asms_pkg::CNT_W-1:0]  cap_eff;
    logic [asms_pkg::ITEM_W-1:0] masked_slot;
    logic                        wr_en;
    logic                        issue_en;
    logic                        hit;

    logic [asms_pkg::CNT_W-1:0]  fill_reg;
    logic [asms_pkg::CNT_W-1:0]  issue_reg;
    logic [asms_pkg::ITEM_W-1:0] item_reg;
    logic [asms_pkg::ITEM_W-1:0] rd_data_reg;
    logic                        rd_vld_reg;
    logic                        rd_last_reg;
    logic                        res_accepted_reg;
    logic                        res_found_reg;
    logic                        out_valid_reg;
    asms_pkg::rsp_t              out_reg;

    assign mask    = asms_pkg::byte_mask(item_bytes);
    assign cap_eff = asms_pkg::eff_capacity(capacity);

    // a put lands at the next free slot unless full
    assign wr_en = cmd.accept && req.operation == asms_pkg::OP_PUT && fill_reg < cap_eff;

    assign issue_en    = cmd.scan && issue_reg < fill_reg;
    assign masked_slot = rd_data_reg & mask;
    assign hit         = rd_vld_reg && masked_slot != '0 && masked_slot == item_reg;

    assign sts.fill_zero = fill_reg == '0;
    assign sts.scan_done = rd_vld_reg && (hit || rd_last_reg);
    assign sts.out_free  = !out_valid_reg || !rsp_stall;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[asms_pkg::ADDR_W-1:0]] <= req.item_value & mask;
        end
        rd_data_reg <= mem[issue_reg[asms_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= req.item_value & mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg         <= '0;
            issue_reg        <= '0;
            rd_vld_reg       <= 1'b0;
            rd_last_reg      <= 1'b0;
            res_accepted_reg <= 1'b0;
            res_found_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_reg          <= '0;
        end
        else
        begin
            rd_vld_reg  <= issue_en;
            rd_last_reg <= issue_reg == fill_reg - asms_pkg::CNT_W'(1);
            if (wr_en)
            begin
                fill_reg <= fill_reg + asms_pkg::CNT_W'(1);
            end
            if (cmd.accept)
            begin
                issue_reg        <= '0;
                res_accepted_reg <= wr_en;
                res_found_reg    <= 1'b0;
            end
            else if (issue_en)
            begin
                issue_reg <= issue_reg + asms_pkg::CNT_W'(1);
            end
            if (cmd.scan && hit)
            begin
                res_found_reg <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg      <= 1'b1;
                out_reg.accepted   <= res_accepted_reg;
                out_reg.found      <= res_found_reg;
                out_reg.is_full    <= fill_reg >= cap_eff;
                out_reg.fill_count <= fill_reg;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `ASMS_ASSERT_ALWAYS(a_fill_bounded, clk, fill_reg <= asms_pkg::CNT_W'(asms_pkg::DEPTH), "fill count beyond depth")
    `ASMS_ASSERT(a_load_sets_valid, clk, rst_n, cmd.load_out |=> out_valid_reg, "result load did not raise valid")
    `ASMS_ASSERT(a_hit_sets_found, clk, rst_n, (cmd.scan && hit) |=> res_found_reg, "match not recorded")
    `ASMS_ASSERT(a_put_grows_fill, clk, rst_n, wr_en |=> fill_reg == $past(fill_reg) + asms_pkg::CNT_W'(1), "stored put did not advance fill count")

endmodule

/* hdl/append_store_membership_search.sv */
// append-only store of up to 64 items of 64 bits with a linear membership search.
// each request transaction carries an operation (0 put, 1 lookup) and an item; each
// produces exactly one response transaction with accepted, found, is_full and the
// fill count after the item. a put goes straight from acceptance to the result
// hand-off; a lookup on a non-empty store first runs a scan that reads one slot per
// cycle from the slot memory, which has separate read and write ports and a
// registered read, and stops early at the first match. the response sits in
// its own output register, so the next request is taken while it waits. only the
// low item_bytes bytes are stored and compared; slots that are zero in those bytes
// never match. capacity above 64 acts as 64. reset empties the store; no clearing
// pass is needed since only filled slots are read. registers: item_bytes at byte
// address 0, capacity at byte address 4; write only while the block is idle.
module append_store_membership_search (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 req_valid,
    output logic                 req_stall,
    input  asms_pkg::req_t       req,
    // response channel
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output asms_pkg::rsp_t       rsp,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic [2:0] ADDR_ITEM_BYTES = 3'(asms_pkg::REG_ITEM_BYTES * 4);
    localparam logic [2:0] ADDR_CAPACITY   = 3'(asms_pkg::REG_CAPACITY * 4);

    logic [asms_pkg::IB_W-1:0]  item_bytes_reg;
    logic [asms_pkg::CAP_W-1:0] capacity_reg;
    logic                       cfg_wr;

    asms_pkg::ctrl_cmd_t cmd;
    asms_pkg::dp_sts_t   sts;

    // register file, written on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_bytes_reg <= asms_pkg::IB_W'(8);
            capacity_reg   <= asms_pkg::CAP_W'(64);
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                ADDR_ITEM_BYTES: item_bytes_reg <= pwdata[asms_pkg::IB_W-1:0];
                ADDR_CAPACITY:   capacity_reg   <= pwdata[asms_pkg::CAP_W-1:0];
                default:         ;
            endcase
        end
    end

    // read back, unmapped addresses return zero
    always_comb
    begin
        prdata = '0;
        unique case (paddr)
            ADDR_ITEM_BYTES: prdata = 32'(item_bytes_reg);
            ADDR_CAPACITY:   prdata = 32'(capacity_reg);
            default:         prdata = '0;
        endcase
    end

    // sequencing: idle, slot scan, result hand-off
    asms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req.operation),
        .sts       (sts),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    // slot memory, fill count, comparator and response register
    asms_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req        (req),
        .item_bytes (item_bytes_reg),
        .capacity   (capacity_reg),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule
